### hw/rtl/m3i_pkg.sv
// m3i_pkg: shared types and constants for the 3x3 matrix inverse block
// no dependencies
package m3i_pkg;

  // number of matrix entries and width of one entry
  localparam int unsigned NumEnt   = 9;
  localparam int unsigned EntryW   = 16;
  localparam int unsigned ProdW    = 2 * EntryW;          // pair product
  localparam int unsigned CofW     = ProdW + 1;           // cofactor
  localparam int unsigned DetProdW = CofW + EntryW;       // cofactor times entry
  localparam int unsigned DetW     = DetProdW + 2;        // sum of three
  localparam int unsigned QuotW    = 32;                  // result width
  localparam int unsigned QShift   = 24;                  // dividend shift
  localparam int unsigned RemW     = DetW;                // partial remainder
  localparam int unsigned QDepth   = 4;                   // front/back queue
  localparam int unsigned QPtrW    = $clog2(QDepth);

  typedef logic signed [EntryW-1:0]   entry_t;
  typedef logic signed [ProdW-1:0]    prod_t;
  typedef logic signed [CofW-1:0]     cof_t;
  typedef logic signed [DetProdW-1:0] det_prod_t;
  typedef logic signed [DetW-1:0]     det_t;
  typedef logic        [QuotW-1:0]    quot_t;

  // one item as it travels from the front part to the back part
  typedef struct packed {
    cof_t [NumEnt-1:0] cof;
    det_t              det;
  } item_t;

endpackage

### hw/rtl/m3i_front.sv
// m3i_front: cofactor and determinant pipeline (four register stages)
// depends on m3i_pkg
module m3i_front import m3i_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  entry_t [NumEnt-1:0]    a_i,
  output logic                   valid_o,
  output item_t                  item_o
);

  prod_t  [17:0]       p_q, p_d;
  entry_t [2:0]        r1_q, r2_q;
  cof_t   [NumEnt-1:0] c2_q, c2_d, c3_q;
  det_prod_t [2:0]     dp_q, dp_d;
  item_t               it_q, it_d;
  logic                v1_q, v2_q, v3_q, v4_q;

  function automatic prod_t mul(entry_t x, entry_t y);
    return prod_t'(x) * prod_t'(y);
  endfunction

  // pair products, two for each cofactor
  always_comb begin
    p_d[0]  = mul(a_i[4], a_i[8]); p_d[1]  = mul(a_i[5], a_i[7]);
    p_d[2]  = mul(a_i[2], a_i[7]); p_d[3]  = mul(a_i[1], a_i[8]);
    p_d[4]  = mul(a_i[1], a_i[5]); p_d[5]  = mul(a_i[2], a_i[4]);
    p_d[6]  = mul(a_i[5], a_i[6]); p_d[7]  = mul(a_i[3], a_i[8]);
    p_d[8]  = mul(a_i[0], a_i[8]); p_d[9]  = mul(a_i[2], a_i[6]);
    p_d[10] = mul(a_i[2], a_i[3]); p_d[11] = mul(a_i[0], a_i[5]);
    p_d[12] = mul(a_i[3], a_i[7]); p_d[13] = mul(a_i[4], a_i[6]);
    p_d[14] = mul(a_i[1], a_i[6]); p_d[15] = mul(a_i[0], a_i[7]);
    p_d[16] = mul(a_i[0], a_i[4]); p_d[17] = mul(a_i[1], a_i[3]);
  end

  // cofactors as differences of product pairs
  always_comb begin
    for (int k = 0; k < NumEnt; k++) begin
      c2_d[k] = cof_t'(p_q[2*k]) - cof_t'(p_q[2*k+1]);
    end
  end

  // determinant expanded along row 0
  always_comb begin
    dp_d[0] = det_prod_t'(c2_q[0]) * det_prod_t'(r2_q[0]);
    dp_d[1] = det_prod_t'(c2_q[3]) * det_prod_t'(r2_q[1]);
    dp_d[2] = det_prod_t'(c2_q[6]) * det_prod_t'(r2_q[2]);
  end

  always_comb begin
    it_d.cof = c3_q;
    it_d.det = det_t'(dp_q[0]) + det_t'(dp_q[1]) + det_t'(dp_q[2]);
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q  <= p_d;
      r1_q <= a_i[2:0];
      c2_q <= c2_d;
      r2_q <= r1_q;
      dp_q <= dp_d;
      c3_q <= c2_q;
      it_q <= it_d;
    end
  end

  assign valid_o = v4_q;
  assign item_o  = it_q;

endmodule

### hw/rtl/m3i_queue.sv
// m3i_queue: short register queue between front and back parts
// depends on m3i_pkg
module m3i_queue import m3i_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  input  logic  pop_i,
  output item_t item_o,
  output logic  empty_o,
  output logic  full_o
);

  item_t            mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QPtrW:0]   cnt_q;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (!push_i && pop_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= item_i;
  end

  assign item_o  = mem_q[rd_q];
  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (QPtrW+1)'(QDepth));

endmodule

### hw/rtl/m3i_back.sv
// m3i_back: nine pipelined restoring dividers, one quotient bit per stage,
// with saturation and output register; depends on m3i_pkg
module m3i_back import m3i_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  item_t               item_i,
  output logic                valid_o,
  output quot_t [NumEnt-1:0]  quot_o,
  output logic                singular_o
);

  localparam int unsigned NSt = QuotW + 1;

  logic [RemW-1:0]  rem_q  [NSt][NumEnt];
  logic [QuotW-1:0] sh_q   [NSt][NumEnt];
  logic             ovf_q  [NSt][NumEnt];
  logic             neg_q  [NSt][NumEnt];
  logic [RemW-1:0]  dmag_q [NSt];
  logic             sing_q [NSt];
  logic             v_q    [NSt];

  logic [RemW-1:0]  rem_d  [NSt][NumEnt];
  logic [QuotW-1:0] sh_d   [NSt][NumEnt];
  logic [RemW-1:0]  rem0_d [NumEnt];
  logic [QuotW-1:0] sh0_d  [NumEnt];
  logic             ovf_d  [NumEnt];
  logic             neg_d  [NumEnt];
  logic [RemW-1:0]  dmag_d;
  logic [CofW-1:0]  cmag;

  quot_t [NumEnt-1:0] res_q, res_d;
  logic               out_v_q, sing_out_q;

  // set-up: magnitudes, signs and the overflow test on the high part
  always_comb begin
    cmag   = '0;
    dmag_d = item_i.det[DetW-1] ? RemW'(-item_i.det) : RemW'(item_i.det);
    for (int k = 0; k < NumEnt; k++) begin
      cmag      = item_i.cof[k][CofW-1] ? CofW'(-item_i.cof[k]) : CofW'(item_i.cof[k]);
      neg_d[k]  = item_i.cof[k][CofW-1] ^ item_i.det[DetW-1];
      rem0_d[k] = RemW'(cmag[CofW-1:QuotW-QShift]);
      sh0_d[k]  = {cmag[QuotW-QShift-1:0], QShift'(0)};
      ovf_d[k]  = RemW'(cmag[CofW-1:QuotW-QShift]) >= dmag_d;
    end
  end

  // one quotient bit per stage
  always_comb begin
    logic [RemW:0] t;
    t = '0;
    rem_d[0] = rem0_d;
    sh_d[0]  = sh0_d;
    for (int s = 1; s < NSt; s++) begin
      for (int k = 0; k < NumEnt; k++) begin
        t = {rem_q[s-1][k], sh_q[s-1][k][QuotW-1]};
        if (t >= {1'b0, dmag_q[s-1]}) begin
          rem_d[s][k] = RemW'(t - {1'b0, dmag_q[s-1]});
          sh_d[s][k]  = {sh_q[s-1][k][QuotW-2:0], 1'b1};
        end else begin
          rem_d[s][k] = RemW'(t);
          sh_d[s][k]  = {sh_q[s-1][k][QuotW-2:0], 1'b0};
        end
      end
    end
  end

  // sign, saturation, and a zero result when the determinant is zero
  always_comb begin
    for (int k = 0; k < NumEnt; k++) begin
      if (sing_q[NSt-1]) begin
        res_d[k] = '0;
      end else if (!neg_q[NSt-1][k]) begin
        if (ovf_q[NSt-1][k] || sh_q[NSt-1][k][QuotW-1])
          res_d[k] = {1'b0, {(QuotW-1){1'b1}}};
        else
          res_d[k] = sh_q[NSt-1][k];
      end else begin
        if (ovf_q[NSt-1][k] || (sh_q[NSt-1][k][QuotW-1] && |sh_q[NSt-1][k][QuotW-2:0]))
          res_d[k] = {1'b1, {(QuotW-1){1'b0}}};
        else
          res_d[k] = -sh_q[NSt-1][k];
      end
    end
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NSt; s++) v_q[s] <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int s = 1; s < NSt; s++) v_q[s] <= v_q[s-1];
      out_v_q <= v_q[NSt-1];
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dmag_q[0] <= dmag_d;
      sing_q[0] <= (dmag_d == '0);
      for (int k = 0; k < NumEnt; k++) begin
        rem_q[0][k] <= rem_d[0][k];
        sh_q[0][k]  <= sh_d[0][k];
        ovf_q[0][k] <= ovf_d[k];
        neg_q[0][k] <= neg_d[k];
      end
      for (int s = 1; s < NSt; s++) begin
        dmag_q[s] <= dmag_q[s-1];
        sing_q[s] <= sing_q[s-1];
        for (int k = 0; k < NumEnt; k++) begin
          rem_q[s][k] <= rem_d[s][k];
          sh_q[s][k]  <= sh_d[s][k];
          ovf_q[s][k] <= ovf_q[s-1][k];
          neg_q[s][k] <= neg_q[s-1][k];
        end
      end
      res_q      <= res_d;
      sing_out_q <= sing_q[NSt-1];
    end
  end

  assign valid_o    = out_v_q;
  assign quot_o     = res_q;
  assign singular_o = sing_out_q;

endmodule

### hw/rtl/matrix3x3_inverse_top.sv
// matrix3x3_inverse_top: fixed-point 3x3 matrix inverse by the adjugate
// depends on m3i_pkg, m3i_front, m3i_queue, m3i_back
//
// Input channel: in_valid_i / in_stall_o with nine signed Q7.8 entries.
// Output channel: out_valid_o / out_stall_i with nine signed Q15.16 inverse
// entries, saturated to 32 bits, and singular_o (all entries zero when the
// determinant is zero). An item moves when valid is high and stall is low.
// Throughput: one matrix per cycle while the output is not stalled.
// Path from acceptance to result valid with no stalls: four
// stages for products, cofactors and the determinant, one queue write, a
// set-up stage, 32 divider stages (one quotient bit each) and the output
// register. The divider chain is the longest part of this path.
// A stall at the output freezes the back pipeline; the four-entry queue then
// absorbs the front pipeline's items, and in_stall_o rises once it is full.
// Reset clears all valid flags and empties the queue; no results are held.
module matrix3x3_inverse_top import m3i_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_stall_o,
  input  entry_t in_r0c0_i,
  input  entry_t in_r0c1_i,
  input  entry_t in_r0c2_i,
  input  entry_t in_r1c0_i,
  input  entry_t in_r1c1_i,
  input  entry_t in_r1c2_i,
  input  entry_t in_r2c0_i,
  input  entry_t in_r2c1_i,
  input  entry_t in_r2c2_i,
  output logic   out_valid_o,
  input  logic   out_stall_i,
  output quot_t  out_r0c0_o,
  output quot_t  out_r0c1_o,
  output quot_t  out_r0c2_o,
  output quot_t  out_r1c0_o,
  output quot_t  out_r1c1_o,
  output quot_t  out_r1c2_o,
  output quot_t  out_r2c0_o,
  output quot_t  out_r2c1_o,
  output quot_t  out_r2c2_o,
  output logic   singular_o
);

  entry_t [NumEnt-1:0] a;
  quot_t  [NumEnt-1:0] q;
  item_t               f_item, q_item;
  logic                f_valid, q_empty, q_full, front_en, back_en, push, pop;

  assign a = {in_r2c2_i, in_r2c1_i, in_r2c0_i, in_r1c2_i, in_r1c1_i,
              in_r1c0_i, in_r0c2_i, in_r0c1_i, in_r0c0_i};

  // front advances while the queue has room, back while the output drains
  assign front_en   = !q_full;
  assign back_en    = !(out_valid_o && out_stall_i);
  assign push       = front_en && f_valid;
  assign pop        = back_en && !q_empty;
  assign in_stall_o = !front_en;

  m3i_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (front_en),
    .valid_i (in_valid_i),
    .a_i     (a),
    .valid_o (f_valid),
    .item_o  (f_item)
  );

  m3i_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (f_item),
    .pop_i   (pop),
    .item_o  (q_item),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  m3i_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (back_en),
    .valid_i    (pop),
    .item_i     (q_item),
    .valid_o    (out_valid_o),
    .quot_o     (q),
    .singular_o (singular_o)
  );

  assign out_r0c0_o = q[0];
  assign out_r0c1_o = q[1];
  assign out_r0c2_o = q[2];
  assign out_r1c0_o = q[3];
  assign out_r1c1_o = q[4];
  assign out_r1c2_o = q[5];
  assign out_r2c0_o = q[6];
  assign out_r2c1_o = q[7];
  assign out_r2c2_o = q[8];

endmodule
